### rtl/core/pfd_pkg.sv
// Shared widths, register indices, state and step codes and saturation helpers for the filtered-derivative PID core.
package pfd_pkg;

	localparam int DataW = 32;
	localparam int CoefW = 31;
	localparam int DenW  = 47;
	localparam int DigW  = 4;
	localparam int IdxW  = 3;

	localparam logic [IdxW-1:0] REG_KP = 3'd0;
	localparam logic [IdxW-1:0] REG_KI = 3'd1;
	localparam logic [IdxW-1:0] REG_KD = 3'd2;
	localparam logic [IdxW-1:0] REG_N  = 3'd3;
	localparam logic [IdxW-1:0] REG_TS = 3'd4;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MLOAD = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_MFIN  = 3'd3;
	localparam logic [2:0] ST_DLOAD = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DFIN  = 3'd6;
	localparam logic [2:0] ST_SUM   = 3'd7;

	localparam logic [2:0] OP_P   = 3'd0;
	localparam logic [2:0] OP_KTS = 3'd1;
	localparam logic [2:0] OP_I   = 3'd2;
	localparam logic [2:0] OP_KDN = 3'd3;
	localparam logic [2:0] OP_D   = 3'd4;
	localparam logic [2:0] OP_NTS = 3'd5;

	// Clamp a 33-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Clamp a 48-bit signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sh0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (v < -48'sh0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/pid_filtered_derivative_core.sv
// Discrete PID controller with a filtered derivative on the measurement, digit-serial datapath.
//
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | req_type, setpoint, measured
//  out     | out       | out_valid/out_ready  | drive
//
// A control sample runs six products on one 32x4 multiplier at a 4-bit digit per
// cycle, each with a load and a finish step, then a restoring divider retiring
// one quotient bit per cycle, then the final sum.
// A stop word just clears controller state. Reset clears gains and controller state at once.
// The finished result waits in the output register; a stalled output holds the
// sequencer in its last step, and a new word is taken once the sequencer is idle.
module pid_filtered_derivative_core
	import pfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [DataW-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    req_type,
	input  logic signed [DataW-1:0] setpoint,
	input  logic signed [DataW-1:0] measured,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DataW-1:0] drive
);

	// Configuration registers.
	logic signed [31:0] kp_q, ki_q, kd_q;
	logic [CoefW-1:0]   n_q, ts_q;

	// Controller state kept between samples.
	logic signed [31:0] last_pv_q, last_d_q, isum_q;
	logic               first_q;

	// Per-sample working registers.
	logic signed [31:0] e_q, dpv_q, p_q, kts_q, kdn_q, num_q;
	logic [DenW-1:0]    den_q;

	// Sequencer.
	logic [2:0] state_q;
	logic [2:0] op_q;
	logic [4:0] cnt_q;

	// Digit-serial multiplier: magnitudes, sign, accumulator.
	logic [31:0] ma_q, mb_q;
	logic        msign_q;
	logic [63:0] acc_q;

	// Restoring divider.
	logic [DenW-1:0] rem_q;
	logic [31:0]     dq_q, quo_q;
	logic            dsign_q;

	logic               out_v_q;
	logic signed [31:0] drive_q;

	logic                 acc_in, acc_cfg;
	logic signed [31:0]   pv_prev;
	logic signed [32:0]   opa, opb, nega, negb;
	logic [35:0]          part, top;
	logic signed [63:0]   prod;
	logic signed [47:0]   fl;
	logic signed [31:0]   qv;
	logic [DenW:0]        trial;
	logic                 tbit;
	logic signed [31:0]   dval;
	logic signed [33:0]   total;
	logic signed [31:0]   total_sat;
	logic                 out_free;
	logic                 out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign acc_in    = in_valid && in_ready;
	assign acc_cfg   = cfg_valid && cfg_ready;
	assign out_valid = out_v_q;
	assign drive     = drive_q;
	assign out_free  = !out_v_q || out_ready;
	// The output register takes a new word in the same cycle the old one leaves.
	assign out_load  = (state_q == ST_SUM) && out_free;

	// The first sample after reset, a write or a stop sees no change in the measurement.
	assign pv_prev = first_q ? measured : last_pv_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (op_q)
			OP_P: begin
				opa = {kp_q[31], kp_q};
				opb = {e_q[31], e_q};
			end
			OP_KTS: begin
				opa = {ki_q[31], ki_q};
				opb = {2'b00, ts_q};
			end
			OP_I: begin
				opa = {kts_q[31], kts_q};
				opb = {e_q[31], e_q};
			end
			OP_KDN: begin
				opa = {kd_q[31], kd_q};
				opb = {2'b00, n_q};
			end
			OP_D: begin
				opa = {kdn_q[31], kdn_q};
				opb = {dpv_q[31], dpv_q};
			end
			default: begin
				opa = {2'b00, n_q};
				opb = {2'b00, ts_q};
			end
		endcase
		nega = -opa;
		negb = -opb;
	end

	// One 4-bit digit of the multiplier per cycle, accumulated from the top.
	assign part = ma_q * mb_q[DigW-1:0];
	assign top  = {4'b0000, acc_q[63:32]} + part;

	// Product post-processing: restore sign, floor shift by 16, clamp.
	assign prod = msign_q ? -$signed(acc_q) : $signed(acc_q);
	assign fl   = prod[63:16];
	assign qv   = sat48(fl);

	// Divider step: bring in the next dividend bit and try to subtract.
	assign trial = {rem_q, dq_q[31]};
	assign tbit  = (trial >= {1'b0, den_q});
	assign dval  = dsign_q ? -quo_q : quo_q;

	assign total     = 34'(p_q) + 34'(isum_q) + 34'(last_d_q);
	assign total_sat = (total > 34'sh0_7fff_ffff) ? 32'sh7fff_ffff :
	                   (total < -34'sh0_8000_0000) ? 32'sh8000_0000 : total[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_q      <= '0;
			kd_q      <= '0;
			n_q       <= '0;
			ts_q      <= '0;
			last_pv_q <= '0;
			last_d_q  <= '0;
			isum_q    <= '0;
			first_q   <= 1'b1;
			state_q   <= ST_IDLE;
			op_q      <= OP_P;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_v_q && out_ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			if (acc_cfg) begin
				unique case (cfg_index)
					REG_KP: begin kp_q <= cfg_data; first_q <= 1'b1; end
					REG_KI: begin ki_q <= cfg_data; first_q <= 1'b1; end
					REG_KD: begin kd_q <= cfg_data; first_q <= 1'b1; end
					REG_N:  begin n_q <= cfg_data[CoefW-1:0]; first_q <= 1'b1; end
					REG_TS: begin ts_q <= cfg_data[CoefW-1:0]; first_q <= 1'b1; end
					default: begin end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (req_type) begin
							last_pv_q <= '0;
							last_d_q  <= '0;
							isum_q    <= '0;
							first_q   <= 1'b1;
						end else begin
							e_q       <= sat33(33'(setpoint) - 33'(measured));
							dpv_q     <= sat33(33'(measured) - 33'(pv_prev));
							last_pv_q <= measured;
							first_q   <= 1'b0;
							op_q      <= OP_P;
							state_q   <= ST_MLOAD;
						end
					end
				end
				ST_MLOAD: begin
					ma_q    <= opa[32] ? nega[31:0] : opa[31:0];
					mb_q    <= opb[32] ? negb[31:0] : opb[31:0];
					msign_q <= opa[32] ^ opb[32];
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q <= {top, acc_q[31:DigW]};
					mb_q  <= mb_q >> DigW;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(32 / DigW - 1)) begin
						state_q <= ST_MFIN;
					end
				end
				ST_MFIN: begin
					unique case (op_q)
						OP_P:   p_q    <= qv;
						OP_KTS: kts_q  <= qv;
						OP_I:   isum_q <= sat33(33'(isum_q) + 33'(qv));
						OP_KDN: kdn_q  <= qv;
						OP_D:   num_q  <= sat33(33'(qv) + 33'(last_d_q));
						default: den_q <= DenW'(65536) + fl[DenW-1:0];
					endcase
					if (op_q == OP_NTS) begin
						state_q <= ST_DLOAD;
					end else begin
						op_q    <= op_q + 3'd1;
						state_q <= ST_MLOAD;
					end
				end
				ST_DLOAD: begin
					// |num| >> 16 < 2^16 <= den for the top dividend bits, so the
					// first 16 quotient bits are zero and are skipped.
					rem_q   <= DenW'(((num_q[31] ? -num_q : num_q) >> 16) & 32'h0000_ffff)
					           | (num_q == 32'sh8000_0000 ? DenW'(32768) : DenW'(0));
					dq_q    <= {(num_q[31] ? 16'(-num_q) : num_q[15:0]), 16'h0000};
					dsign_q <= num_q[31];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= tbit ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
					dq_q  <= dq_q << 1;
					quo_q <= {quo_q[30:0], tbit};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DFIN;
					end
				end
				ST_DFIN: begin
					last_d_q <= dval;
					state_q  <= ST_SUM;
				end
				default: begin
					if (out_free) begin
						drive_q <= total_sat;
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !req_type) |=> (state_q == ST_MLOAD))
		else $error("control sample did not start the sequencer");
	a_den_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q[DenW-1:16] != '0))
		else $error("divisor below one");
	a_quo_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DFIN) |-> (!quo_q[31] || (dsign_q && quo_q[30:0] == '0)))
		else $error("quotient out of range");
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MLOAD) |-> (op_q <= OP_NTS))
		else $error("bad multiplier step");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not loaded");
`endif

endmodule
